FILE: sv/base64_stream_decoder_core_defines.svh
// Assertion macros used by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define B64SD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define B64SD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/b64sd_pkg.sv
`default_nettype none
package b64sd_pkg;

    localparam int B64SD_FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } b64sd_sextet_t;

    // One decoded group for the output side: nbytes bytes from the top of word.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        last;
    } b64sd_cmd_t;

    typedef struct packed {
        logic [1:0] count;
        logic       stopped;
    } b64sd_status_t;

    function automatic b64sd_sextet_t sextet_of(input logic [7:0] c);
        b64sd_sextet_t r;
        r = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.ok  = 1'b1;
            r.val = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.ok  = 1'b1;
            r.val = 6'(c - 8'h47);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.ok  = 1'b1;
            r.val = 6'(c + 8'h04);
        end else if (c == CHAR_PLUS) begin
            r.ok  = 1'b1;
            r.val = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.ok  = 1'b1;
            r.val = 6'd63;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/b64sd_front.sv
`default_nettype none
module b64sd_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   accept,
    input  wire logic                   kind,
    input  wire logic [7:0]             char_code,
    output b64sd_pkg::b64sd_cmd_t       cmd,
    output logic                        push,
    output b64sd_pkg::b64sd_status_t    status
);
    import b64sd_pkg::*;

    logic [17:0]   store_reg, store_next;
    logic [1:0]    count_reg, count_next;
    logic          stopped_reg, stopped_next;
    b64sd_sextet_t lk;

    assign lk = sextet_of(char_code);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg   <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end else begin
            store_reg   <= store_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb begin
        store_next   = store_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        push         = 1'b0;
        cmd          = '0;
        if (accept) begin
            if (kind == KIND_CHAR) begin
                if (!stopped_reg) begin
                    if (!lk.ok) begin
                        stopped_next = 1'b1;
                    end else if (count_reg != 2'd3) begin
                        store_next = {store_reg[11:0], lk.val};
                        count_next = count_reg + 2'd1;
                    end else begin
                        push        = 1'b1;
                        cmd.word    = {store_reg, lk.val};
                        cmd.nbytes  = 2'd3;
                        store_next  = '0;
                        count_next  = '0;
                    end
                end
            end else begin
                // flush: k held sextets give k-1 bytes, zero filled on the right
                push     = 1'b1;
                cmd.last = 1'b1;
                case (count_reg)
                    2'd2: begin
                        cmd.word   = {store_reg[11:0], 12'h000};
                        cmd.nbytes = 2'd1;
                    end
                    2'd3: begin
                        cmd.word   = {store_reg, 6'h00};
                        cmd.nbytes = 2'd2;
                    end
                    default: begin
                        cmd.word   = '0;
                        cmd.nbytes = 2'd0;
                    end
                endcase
                store_next   = '0;
                count_next   = '0;
                stopped_next = 1'b0;
            end
        end
    end

    assign status.count   = count_reg;
    assign status.stopped = stopped_reg;

endmodule
`default_nettype wire

FILE: sv/b64sd_fifo.sv
`default_nettype none
module b64sd_fifo #(
    parameter int DEPTH = b64sd_pkg::B64SD_FIFO_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  b64sd_pkg::b64sd_cmd_t       push_cmd,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        pop_valid,
    output b64sd_pkg::b64sd_cmd_t       head
);
    import b64sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64sd_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: sv/b64sd_back.sv
`default_nettype none
module b64sd_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cmd_valid,
    input  b64sd_pkg::b64sd_cmd_t       cmd,
    output logic                        cmd_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_data_byte,
    output logic                        m_has_byte,
    output logic                        m_last
);
    import b64sd_pkg::*;

    logic         cur_valid_reg, cur_valid_next;
    b64sd_cmd_t   cur_reg, cur_next;
    logic [1:0]   idx_reg, idx_next;
    logic         final_one;
    logic [7:0]   sel_byte;

    // last request of the current group (a byteless close is a single request)
    assign final_one = (cur_reg.nbytes == 2'd0) || (idx_reg == cur_reg.nbytes - 2'd1);
    assign cmd_pop   = cmd_valid && (!cur_valid_reg || (m_ready && final_one));

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.word[23:16];
            2'd1:    sel_byte = cur_reg.word[15:8];
            default: sel_byte = cur_reg.word[7:0];
        endcase
    end

    assign m_valid     = cur_valid_reg;
    assign m_has_byte  = (cur_reg.nbytes != 2'd0);
    assign m_data_byte = m_has_byte ? sel_byte : 8'h00;
    assign m_last      = cur_reg.last && final_one;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (cmd_pop) begin
            cur_valid_next = 1'b1;
            cur_next       = cmd;
            idx_next       = '0;
        end else if (cur_valid_reg && m_ready) begin
            if (final_one) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule
`default_nettype wire

FILE: sv/base64_stream_decoder_core.sv
`default_nettype none
// Streaming base64 decoder (standard alphabet). One character or end item
// is taken per cycle; every fourth alphabet character completes a group
// whose three bytes leave one per cycle while m_ready is high, and an end
// item flushes a partial group of k sextets as k-1 bytes, closing with a
// request marked last (with no byte if none is left). The first '=' or
// non-alphabet character stops decoding until the end item. The front end
// classifies characters and packs sextets; groups queue in a FIFO_DEPTH
// entry FIFO, and the output stage drains one byte per cycle while m_ready
// is high, so input sustains one item per cycle on ordinary text and
// stalls only when the queue is full. A completing group passes through
// the FIFO and then the output stage register before its first byte.
`include "base64_stream_decoder_core_defines.svh"
module base64_stream_decoder_core #(
    parameter int FIFO_DEPTH = b64sd_pkg::B64SD_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [7:0]  s_char_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_has_byte,
    output logic             m_last
);
    import b64sd_pkg::*;

    logic           s_accept;
    logic           push;
    logic           fifo_full;
    logic           cmd_valid;
    logic           cmd_pop;
    b64sd_cmd_t     push_cmd;
    b64sd_cmd_t     head;
    b64sd_status_t  status;

    assign s_ready  = !fifo_full;
    assign s_accept = s_valid && s_ready;

    b64sd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .kind      (s_kind),
        .char_code (s_char_code),
        .cmd       (push_cmd),
        .push      (push),
        .status    (status)
    );

    b64sd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_valid (cmd_valid),
        .head      (head)
    );

    b64sd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd         (head),
        .cmd_pop     (cmd_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_has_byte  (m_has_byte),
        .m_last      (m_last)
    );

    `B64SD_ASSERT(a_no_overflow, push |-> !fifo_full, "group queued while queue full")
    `B64SD_ASSERT(a_byteless_is_last, (m_valid && !m_has_byte) |-> (m_last && m_data_byte == 8'h00), "byteless request not a clean close")
    `B64SD_ASSERT(a_end_clears, (s_accept && s_kind == KIND_END) |=> (status.count == 2'd0 && !status.stopped), "end item left decoder state")
    `B64SD_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!m_valid && s_ready), "outputs not idle after reset")

endmodule
`default_nettype wire

FILE: test/base64_decode_checker.sv
module base64_decode_checker
    import b64sd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_char_code,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_data_byte,
    input  wire logic       m_has_byte,
    input  wire logic       m_last,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } decoded_byte_t;

    decoded_byte_t byte_q[$];

    // decoder state mirror
    logic [17:0] grp_bits;
    logic [1:0]  grp_cnt;
    bit          halted;
    int          err_total;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        err_total   = 0;
        grp_bits    = '0;
        grp_cnt     = '0;
        halted      = 1'b0;
    end

    // {in alphabet, six-bit value}
    function automatic logic [6:0] alpha_index(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 52)};
        if (c == CHAR_PLUS)       return {1'b1, 6'd62};
        if (c == CHAR_SLASH)      return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    task automatic decode_request(input logic kind, input logic [7:0] code);
        logic [6:0]  sx;
        logic [23:0] w;
        int          k;
        if (kind == KIND_CHAR) begin
            if (halted) return;
            sx = alpha_index(code);
            if (!sx[6]) begin
                halted = 1'b1;
                return;
            end
            if (grp_cnt < 3) begin
                grp_bits = {grp_bits[11:0], sx[5:0]};
                grp_cnt  = grp_cnt + 1'b1;
            end else begin
                w = {grp_bits, sx[5:0]};
                byte_q.push_back('{w[23:16], 1'b1, 1'b0});
                byte_q.push_back('{w[15:8],  1'b1, 1'b0});
                byte_q.push_back('{w[7:0],   1'b1, 1'b0});
                grp_bits = '0;
                grp_cnt  = '0;
            end
        end else begin
            k = grp_cnt;
            if (k >= 2) begin
                // left-align held sextets, missing positions are zero
                w = {6'd0, grp_bits} << (6 * (4 - k));
                for (int i = 0; i < k - 1; i++)
                    byte_q.push_back('{w[23 - 8 * i -: 8], 1'b1, (i == k - 2)});
            end else begin
                byte_q.push_back('{8'd0, 1'b0, 1'b1});
            end
            grp_bits = '0;
            grp_cnt  = '0;
            halted   = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        decoded_byte_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                decode_request(s_kind, s_char_code);
            if (m_valid && m_ready) begin
                if (byte_q.size() == 0) begin
                    err_total++;
                    if (err_total <= REPORT_LIMIT)
                        $display("%0t: unexpected byte data=%h has=%b last=%b",
                                 $realtime, m_data_byte, m_has_byte, m_last);
                end else begin
                    want = byte_q.pop_front();
                    if (m_data_byte !== want.data_byte || m_has_byte !== want.has_byte ||
                        m_last !== want.last) begin
                        err_total++;
                        if (err_total <= REPORT_LIMIT)
                            $display("%0t: mismatch exp data=%h has=%b last=%b, got %h %b %b",
                                     $realtime, want.data_byte, want.has_byte, want.last,
                                     m_data_byte, m_has_byte, m_last);
                    end
                end
            end
        end
        mismatches  <= err_total;
        outstanding <= byte_q.size();
    end

endmodule

FILE: test/tb_base64_stream_decoder_core.sv
module tb_base64_stream_decoder_core;
    import b64sd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 470;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_kind      = KIND_CHAR;
    logic [7:0] s_char_code = 8'd0;
    logic       m_ready     = 1'b0;
    wire logic  s_ready;
    wire logic  m_valid;
    wire logic [7:0] m_data_byte;
    wire logic  m_has_byte;
    wire logic  m_last;

    int mismatches;
    int outstanding;
    int sent_count = 0;
    bit calm = 1'b0;

    base64_stream_decoder_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_has_byte  (m_has_byte),
        .m_last      (m_last)
    );

    base64_decode_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_has_byte  (m_has_byte),
        .m_last      (m_last),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end

    initial begin
        #2_000_000;
        $display("tb_base64_stream_decoder_core: errors");
        $finish;
    end

    function automatic logic [7:0] sextet_char(input int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    task automatic send_request(input logic kind, input logic [7:0] code);
        while (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_char_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_request(KIND_CHAR, txt[i]);
    endtask

    // mostly well-formed strings, some padded, some with junk mixed in
    task automatic send_random_string();
        int len;
        int noise_at;
        int pads;
        logic [7:0] c;
        len = $urandom_range(12);
        if ($urandom_range(9) == 0) len = $urandom_range(40);
        noise_at = ($urandom_range(4) == 0) ? $urandom_range(len) : -1;
        for (int j = 0; j < len; j++) begin
            if (j == noise_at) c = 8'($urandom_range(255));
            else c = sextet_char($urandom_range(63));
            send_request(KIND_CHAR, c);
        end
        if ($urandom_range(3) == 0) begin
            pads = $urandom_range(2, 1);
            for (int j = 0; j < pads; j++)
                send_request(KIND_CHAR, CHAR_PAD);
            // trailing junk after the pad is dropped by the block
            repeat ($urandom_range(2)) send_request(KIND_CHAR, 8'($urandom_range(255)));
        end
        send_request(KIND_END, 8'($urandom_range(255)));
    endtask

    initial begin
        int strings;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full group, then end with nothing left
        send_text("TWFu");
        send_request(KIND_END, 8'h00);
        // pad stops decoding, later chars ignored
        send_text("TWE=A");
        send_request(KIND_END, 8'hFF);
        // non-alphabet byte stops with two sextets held
        send_text("Tq");
        send_request(KIND_CHAR, 8'hFF);
        send_request(KIND_END, 8'h80);
        // single sextet, then a zero byte as stop
        send_text("/");
        send_request(KIND_CHAR, 8'h00);
        send_request(KIND_END, 8'hFF);
        // bare end
        send_request(KIND_END, 8'h00);
        // alphabet extremes, three sextets at end
        send_text("+9z0aZA");
        send_request(KIND_END, 8'h3D);

        strings = 0;
        while (sent_count < RANDOM_ITEMS) begin
            if (strings == 12) begin
                s_valid <= 1'b0;
                // let the count see the last accepted request
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
            calm = (strings >= 25 && strings < 45);
            send_random_string();
            strings++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_base64_stream_decoder_core: clean");
        end else begin
            $display("tb_base64_stream_decoder_core: errors");
        end
        $finish;
    end

endmodule
